### src/wtfp_pkg.sv
package wtfp_pkg;

    // command codes on the input channel
    localparam logic [1:0] CMD_UPDATE = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_STOP   = 2'd2;

    // configuration register map
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 19;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_BAND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRIP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP = 3'd4;

    // field widths
    localparam int unsigned BAND_W  = 19;
    localparam int unsigned SPEED_W = 7;
    localparam int unsigned LEVEL_W = 7;
    localparam int unsigned CODE_W  = 12;
    localparam int unsigned DAC_W   = 16;
    localparam int unsigned TIME_W  = 32;

    // reset values
    localparam logic [BAND_W-1:0]  RST_TARGET    = 19'd0;
    localparam logic [BAND_W-1:0]  RST_SLOW_BAND = 19'd100;
    localparam logic [BAND_W-1:0]  RST_DRIP      = 19'd0;
    localparam logic [SPEED_W-1:0] RST_MAX_SPEED = 7'd0;
    localparam logic [SPEED_W-1:0] RST_RAMP_STEP = 7'd1;

    // fixed constants of the control law
    localparam logic [DAC_W-1:0]   DAC_FRAME      = 16'h3000;
    localparam logic [LEVEL_W-1:0] FULL_SCALE     = 7'd100;
    localparam logic [TIME_W-1:0]  START_DELAY_MS = 32'd20;
    localparam logic [CODE_W-1:0]  CODE_MAX       = 12'hFFF;

    // serial divider: quotient width and step counts
    localparam int unsigned QUO_W      = 13;
    localparam int unsigned CNT_W      = 4;
    localparam int unsigned SLOW_STEPS = 7;
    localparam int unsigned CODE_STEPS = 13;
    // x*40/100 == (2x)/5
    localparam int unsigned CODE_DIVISOR = 5;

endpackage

### src/wtfp_if.sv
interface wtfp_in_if #(
    parameter int WEIGHT_BITS = 20
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    command;
    logic signed [WEIGHT_BITS-1:0] weight;
    logic [31:0]                   now_ms;

    modport source (output valid, command, weight, now_ms, input ready);
    modport sink   (input valid, command, weight, now_ms, output ready);
endinterface

interface wtfp_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] dac_word;
    logic        run_enable;
    logic        filling;
    logic        beep;

    modport source (output valid, dac_word, run_enable, filling, beep, input ready);
    modport sink   (input valid, dac_word, run_enable, filling, beep, output ready);
endinterface

interface wtfp_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [wtfp_pkg::CFG_IDX_W-1:0]     index;
    logic [wtfp_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/weight_target_fill_pump_control.sv
// Fill pump controller: drives a pump DAC until a scale reaches a target weight.
// Channels: i_in (command, weight, now_ms), o_out (dac_word, run_enable, filling,
// beep), i_cfg (register index + data, always ready; the user writes it only while
// idle, which the block leaves unchecked). One result beat per input beat, in order.
// Throughput: one input beat at a time. Start, stop, idle updates, unused commands
// and the update that reaches the target pass from the prepare state straight to
// the done state, where the result is loaded. A tapering update runs the slowdown
// quotient through the bit-serial divider and then the DAC code (2*f*max_speed/5),
// one quotient bit per cycle. A saturated taper or a zero band skips the first
// division.
// The output register parts the channels: a new beat is taken while the previous
// result still waits. If the receiver stalls, the finished result is held in the
// controller until the output register frees up.
// Reset (i_rst_n low, synchronous): registers go to their documented defaults,
// the fill cycle is inactive, speed code 0, run line low, no result pending.
module weight_target_fill_pump_control #(
    parameter int WEIGHT_BITS = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wtfp_in_if.sink       i_in,
    wtfp_out_if.source    o_out,
    wtfp_cfg_if.sink      i_cfg
);

    localparam int DW = ((WEIGHT_BITS > 20) ? WEIGHT_BITS : 20) + 2;
    localparam int RW = DW + 7;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_PREP  = 8'b0000_0010,
        S_SCALE = 8'b0000_0100,
        S_CHK   = 8'b0000_1000,
        S_DIV1  = 8'b0001_0000,
        S_MUL   = 8'b0010_0000,
        S_DIV2  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state;

    // configuration
    logic [wtfp_pkg::BAND_W-1:0]  r_target, r_band, r_drip;
    logic [wtfp_pkg::SPEED_W-1:0] r_max_speed, r_step;

    // controller state
    logic                          r_active;
    logic [wtfp_pkg::LEVEL_W-1:0]  r_ramp;
    logic [wtfp_pkg::TIME_W-1:0]   r_begin;
    logic [wtfp_pkg::CODE_W-1:0]   r_speed;
    logic                          r_enable;
    logic                          r_beep;

    // latched input beat
    logic [1:0]                    r_cmd;
    logic signed [WEIGHT_BITS-1:0] r_w;
    logic [wtfp_pkg::TIME_W-1:0]   r_now;

    // datapath
    logic [DW-2:0]                 r_d;
    logic [RW-1:0]                 r_rem, r_dsr;
    logic [wtfp_pkg::QUO_W-1:0]    r_quo;
    logic [wtfp_pkg::CNT_W-1:0]    r_cnt;
    logic [wtfp_pkg::LEVEL_W-1:0]  r_slow;

    // output register
    logic                          r_ovalid;
    logic [wtfp_pkg::DAC_W-1:0]    r_odac;
    logic                          r_orun, r_ofill, r_obeep;

    logic                          in_acc, cfg_acc, out_free;
    logic signed [DW-1:0]          w_ext, tgt_ext, band_ext, drip_ext, d_raw;
    logic                          stop_hit, en_hit;
    logic [wtfp_pkg::LEVEL_W:0]    ramp_sum;
    logic [wtfp_pkg::LEVEL_W-1:0]  ramp_new;
    logic [wtfp_pkg::TIME_W-1:0]   elapsed;
    logic [RW-1:0]                 num100, band_sh7;
    logic                          div_ge;
    logic [RW-1:0]                 n_rem;
    logic [wtfp_pkg::QUO_W-1:0]    n_quo;
    logic [wtfp_pkg::LEVEL_W-1:0]  frac;
    logic [2*wtfp_pkg::SPEED_W-1:0] prod;
    logic [wtfp_pkg::CODE_W-1:0]   code_sat;

    assign in_acc   = i_in.valid && i_in.ready;
    assign cfg_acc  = i_cfg.valid && i_cfg.ready;
    assign out_free = !r_ovalid || o_out.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid      = r_ovalid;
    assign o_out.dac_word   = r_odac;
    assign o_out.run_enable = r_orun;
    assign o_out.filling    = r_ofill;
    assign o_out.beep       = r_obeep;

    // weight arithmetic, signed at DW bits
    always_comb begin
        w_ext    = DW'(r_w);
        tgt_ext  = signed'(DW'(r_target));
        band_ext = signed'(DW'(r_band));
        drip_ext = signed'(DW'(r_drip));
        d_raw    = w_ext - tgt_ext + band_ext;
        stop_hit = (w_ext >= (tgt_ext - drip_ext));
    end

    // ramp and start delay
    assign ramp_sum = {1'b0, r_ramp} + {1'b0, r_step};
    assign ramp_new = (ramp_sum > {1'b0, wtfp_pkg::FULL_SCALE}) ?
                      wtfp_pkg::FULL_SCALE : ramp_sum[wtfp_pkg::LEVEL_W-1:0];
    assign elapsed  = r_now - r_begin;
    assign en_hit   = (elapsed > wtfp_pkg::START_DELAY_MS);

    // 100*d as shift-add, and the saturation threshold band*128
    assign num100   = (RW'(r_d) << 6) + (RW'(r_d) << 5) + (RW'(r_d) << 2);
    assign band_sh7 = RW'(r_band) << 7;

    // one restoring divider step
    assign div_ge = (r_rem >= r_dsr);
    assign n_rem  = div_ge ? (r_rem - r_dsr) : r_rem;
    assign n_quo  = {r_quo[wtfp_pkg::QUO_W-2:0], div_ge};

    // speed fraction and DAC code (code taken from the quotient after the last step)
    assign frac     = (r_ramp > r_slow) ? (r_ramp - r_slow) : '0;
    assign prod     = (2*wtfp_pkg::SPEED_W)'(frac) * (2*wtfp_pkg::SPEED_W)'(r_max_speed);
    assign code_sat = n_quo[wtfp_pkg::QUO_W-1] ? wtfp_pkg::CODE_MAX :
                      n_quo[wtfp_pkg::CODE_W-1:0];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= wtfp_pkg::RST_TARGET;
            r_band      <= wtfp_pkg::RST_SLOW_BAND;
            r_drip      <= wtfp_pkg::RST_DRIP;
            r_max_speed <= wtfp_pkg::RST_MAX_SPEED;
            r_step      <= wtfp_pkg::RST_RAMP_STEP;
        end else if (cfg_acc) begin
            case (i_cfg.index)
                wtfp_pkg::REG_TARGET:    r_target    <= i_cfg.data;
                wtfp_pkg::REG_SLOW_BAND: r_band      <= i_cfg.data;
                wtfp_pkg::REG_DRIP:      r_drip      <= i_cfg.data;
                wtfp_pkg::REG_MAX_SPEED: r_max_speed <= i_cfg.data[wtfp_pkg::SPEED_W-1:0];
                wtfp_pkg::REG_RAMP_STEP: r_step      <= i_cfg.data[wtfp_pkg::SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // input beat capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= i_in.command;
            r_w   <= i_in.weight;
            r_now <= i_in.now_ms;
        end
    end

    // sequencer and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= 1'b0;
            r_ramp   <= '0;
            r_begin  <= '0;
            r_speed  <= '0;
            r_enable <= 1'b0;
            r_beep   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_beep  <= 1'b0;
                    r_state <= S_DONE;
                    case (r_cmd)
                        wtfp_pkg::CMD_START: begin
                            r_active <= 1'b1;
                            r_begin  <= r_now;
                            r_ramp   <= '0;
                        end
                        wtfp_pkg::CMD_STOP: begin
                            r_active <= 1'b0;
                            r_enable <= 1'b0;
                            r_speed  <= '0;
                        end
                        wtfp_pkg::CMD_UPDATE: begin
                            if (r_active) begin
                                r_ramp <= ramp_new;
                                if (stop_hit) begin
                                    r_beep   <= 1'b1;
                                    r_active <= 1'b0;
                                    r_enable <= 1'b0;
                                    r_speed  <= '0;
                                end else begin
                                    if (en_hit) begin
                                        r_enable <= 1'b1;
                                    end
                                    r_state <= S_SCALE;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                S_SCALE: r_state <= S_CHK;
                S_CHK: begin
                    if (r_band == '0 || r_rem >= band_sh7) begin
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (r_cnt == wtfp_pkg::CNT_W'(1)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_DIV2;
                S_DIV2: begin
                    if (r_cnt == wtfp_pkg::CNT_W'(1)) begin
                        r_speed <= code_sat;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // serial datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_PREP: begin
                r_d <= d_raw[DW-1] ? '0 : d_raw[DW-2:0];
            end
            S_SCALE: begin
                r_rem <= num100;
            end
            S_CHK: begin
                r_quo <= '0;
                r_dsr <= RW'(r_band) << (wtfp_pkg::SLOW_STEPS - 1);
                r_cnt <= wtfp_pkg::CNT_W'(wtfp_pkg::SLOW_STEPS);
                if (r_band == '0) begin
                    r_slow <= (r_rem != '0) ? wtfp_pkg::FULL_SCALE : '0;
                end else begin
                    r_slow <= wtfp_pkg::FULL_SCALE;
                end
            end
            S_DIV1: begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_dsr <= r_dsr >> 1;
                r_cnt <= r_cnt - wtfp_pkg::CNT_W'(1);
                if (r_cnt == wtfp_pkg::CNT_W'(1)) begin
                    r_slow <= (n_quo[wtfp_pkg::LEVEL_W-1:0] > wtfp_pkg::FULL_SCALE) ?
                              wtfp_pkg::FULL_SCALE : n_quo[wtfp_pkg::LEVEL_W-1:0];
                end
            end
            S_MUL: begin
                r_rem <= RW'({prod, 1'b0});
                r_dsr <= RW'(wtfp_pkg::CODE_DIVISOR) << (wtfp_pkg::CODE_STEPS - 1);
                r_quo <= '0;
                r_cnt <= wtfp_pkg::CNT_W'(wtfp_pkg::CODE_STEPS);
            end
            S_DIV2: begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_dsr <= r_dsr >> 1;
                r_cnt <= r_cnt - wtfp_pkg::CNT_W'(1);
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_odac  <= wtfp_pkg::DAC_FRAME | wtfp_pkg::DAC_W'(r_speed);
            r_orun  <= r_enable;
            r_ofill <= r_active;
            r_obeep <= r_beep;
        end
    end

endmodule

### src/wtfp_checker.sv
module wtfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_dac_word,
    input logic        i_run_enable,
    input logic        i_filling,
    input logic        i_beep
);

    // a stalled result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_dac_word) && $stable(i_run_enable)
             && $stable(i_filling) && $stable(i_beep)))
        else $error("result beat changed while stalled");

    // the stopping beat ends the cycle with the pump off
    a_beep_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_beep) |->
            (!i_filling && !i_run_enable && i_dac_word == wtfp_pkg::DAC_FRAME))
        else $error("beep without pump shut off");

    // run line is only up during a fill cycle
    a_run_needs_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_run_enable) |-> i_filling)
        else $error("run line high outside fill cycle");

    // one beat in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken while busy");

endmodule

bind weight_target_fill_pump_control wtfp_checker u_wtfp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_dac_word   (o_out.dac_word),
    .i_run_enable (o_out.run_enable),
    .i_filling    (o_out.filling),
    .i_beep       (o_out.beep)
);

### tb/weight_target_fill_pump_control_test.sv
module weight_target_fill_pump_control_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WB = 20;
    localparam int SETTLE_CYCLES = 40;
    localparam int SPEED_GAIN = 40;
    localparam int unsigned BAND_W     = wtfp_pkg::BAND_W;
    localparam int unsigned SPEED_W    = wtfp_pkg::SPEED_W;
    localparam int unsigned LEVEL_W    = wtfp_pkg::LEVEL_W;
    localparam int unsigned CODE_W     = wtfp_pkg::CODE_W;
    localparam int unsigned DAC_W      = wtfp_pkg::DAC_W;
    localparam int unsigned TIME_W     = wtfp_pkg::TIME_W;
    localparam int unsigned CFG_IDX_W  = wtfp_pkg::CFG_IDX_W;
    localparam int unsigned CFG_DATA_W = wtfp_pkg::CFG_DATA_W;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam longint W_MIN = -(longint'(1) <<< (WB - 1));
    localparam longint W_MAX = (longint'(1) <<< (WB - 1)) - 1;
    localparam longint FULL = longint'(wtfp_pkg::FULL_SCALE);
    localparam longint CODE_TOP = longint'(wtfp_pkg::CODE_MAX);

    typedef struct packed {
        logic [1:0]           command;
        logic signed [WB-1:0] weight;
        logic [TIME_W-1:0]    now_ms;
    } t_pump_cmd;

    typedef struct packed {
        logic [DAC_W-1:0] dac_word;
        logic             run_enable;
        logic             filling;
        logic             beep;
    } t_pump_res;

    logic i_clk = 1'b0;
    logic i_rst_n;

    wtfp_in_if #(.WEIGHT_BITS(WB)) in_if ();
    wtfp_out_if                    out_if ();
    wtfp_cfg_if                    cfg_if ();

    weight_target_fill_pump_control #(
        .WEIGHT_BITS(WB)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // shadow copy of the controller registers and state
    logic [BAND_W-1:0]  set_target    = wtfp_pkg::RST_TARGET;
    logic [BAND_W-1:0]  set_band      = wtfp_pkg::RST_SLOW_BAND;
    logic [BAND_W-1:0]  set_drip      = wtfp_pkg::RST_DRIP;
    logic [SPEED_W-1:0] set_max_speed = wtfp_pkg::RST_MAX_SPEED;
    logic [SPEED_W-1:0] set_ramp_step = wtfp_pkg::RST_RAMP_STEP;

    logic               fill_on  = 1'b0;
    logic [LEVEL_W-1:0] ramp_lvl = '0;
    logic [TIME_W-1:0]  t_begin  = '0;
    logic [CODE_W-1:0]  code_now = '0;
    logic               run_line = 1'b0;

    t_pump_cmd pending_q[$];
    t_pump_res expected_q[$];
    int        beats_queued = 0;
    int        beats_taken  = 0;
    int        errors       = 0;
    bit        in_taken     = 1'b0;
    int        in_gap       = 0;
    int        out_stall    = 0;
    int        gap_pct      = 0;
    bit        steady       = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // one control step of the pump controller on the shadow state
    function automatic t_pump_res pump_step(t_pump_cmd c);
        t_pump_res         r;
        longint            w, d, slow, f, code, lvl;
        logic [TIME_W-1:0] elapsed;
        w = longint'($signed(c.weight));
        r.beep = 1'b0;
        case (c.command)
            wtfp_pkg::CMD_START: begin
                fill_on  = 1'b1;
                t_begin  = c.now_ms;
                ramp_lvl = '0;
            end
            wtfp_pkg::CMD_STOP: begin
                fill_on  = 1'b0;
                run_line = 1'b0;
                code_now = '0;
            end
            wtfp_pkg::CMD_UPDATE: begin
                if (fill_on) begin
                    lvl = longint'(ramp_lvl) + longint'(set_ramp_step);
                    if (lvl > FULL) lvl = FULL;
                    ramp_lvl = LEVEL_W'(lvl);

                    // taper inside the slowdown band
                    d = w - longint'(set_target) + longint'(set_band);
                    if (d < 0) d = 0;
                    if (set_band == '0)
                        slow = (d > 0) ? FULL : 0;
                    else
                        slow = (d * FULL) / longint'(set_band);
                    if (slow > FULL) slow = FULL;

                    f = lvl - slow;
                    if (f < 0) f = 0;
                    if (f > FULL) f = FULL;

                    code = (f * longint'(set_max_speed) * SPEED_GAIN) / FULL;
                    if (code > CODE_TOP) code = CODE_TOP;
                    code_now = CODE_W'(code);

                    elapsed = c.now_ms - t_begin;
                    if (elapsed > wtfp_pkg::START_DELAY_MS) run_line = 1'b1;

                    // target reached (less drip)
                    if (w >= longint'(set_target) - longint'(set_drip)) begin
                        r.beep   = 1'b1;
                        run_line = 1'b0;
                        code_now = '0;
                        fill_on  = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        r.dac_word   = wtfp_pkg::DAC_FRAME | DAC_W'(code_now);
        r.run_enable = run_line;
        r.filling    = fill_on;
        return r;
    endfunction

    task automatic check_field(string name, logic [DAC_W-1:0] want,
                               logic [DAC_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // input beat driver, fed from pending_q
    always @(negedge i_clk) begin : feed_in
        t_pump_cmd beat;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_taken) begin
            if (in_gap > 0) begin
                in_gap--;
                in_if.valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                beat = pending_q.pop_front();
                in_if.command <= beat.command;
                in_if.weight  <= beat.weight;
                in_if.now_ms  <= beat.now_ms;
                in_if.valid   <= 1'b1;
                if (!steady && $urandom_range(0, 99) < gap_pct)
                    in_gap = $urandom_range(1, 7);
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        if (out_stall > 0) begin
            out_stall--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
            if (!steady && $urandom_range(0, 99) < gap_pct)
                out_stall = $urandom_range(1, 7);
        end
    end

    // monitor: predict on accepted input beats, check result beats
    always @(posedge i_clk) begin : watch
        t_pump_cmd seen;
        t_pump_res want;
        in_taken = i_rst_n && in_if.valid && in_if.ready;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (expected_q.size() == 0) begin
                    $error("result beat with no expectation pending");
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("dac_word", want.dac_word, out_if.dac_word);
                    check_field("run_enable", DAC_W'(want.run_enable),
                                DAC_W'(out_if.run_enable));
                    check_field("filling", DAC_W'(want.filling), DAC_W'(out_if.filling));
                    check_field("beep", DAC_W'(want.beep), DAC_W'(out_if.beep));
                end
            end
            if (in_taken) begin
                seen.command = in_if.command;
                seen.weight  = in_if.weight;
                seen.now_ms  = in_if.now_ms;
                expected_q.push_back(pump_step(seen));
                beats_taken++;
            end
        end
    end

    function automatic logic [WB-1:0] clamp_weight(longint v);
        if (v < W_MIN) v = W_MIN;
        if (v > W_MAX) v = W_MAX;
        return v[WB-1:0];
    endfunction

    task automatic add_beat(logic [1:0] cmd, logic [WB-1:0] w, logic [TIME_W-1:0] t);
        t_pump_cmd b;
        b.command = cmd;
        b.weight  = w;
        b.now_ms  = t;
        pending_q.push_back(b);
        beats_queued++;
    endtask

    task automatic add_noise();
        add_beat(2'($urandom_range(0, 3)), WB'($urandom()), $urandom());
    endtask

    // register write; the shadow copy follows on the accepting edge
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        cfg_if.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            wtfp_pkg::REG_TARGET:    set_target    = val;
            wtfp_pkg::REG_SLOW_BAND: set_band      = val;
            wtfp_pkg::REG_DRIP:      set_drip      = val;
            wtfp_pkg::REG_MAX_SPEED: set_max_speed = val[SPEED_W-1:0];
            wtfp_pkg::REG_RAMP_STEP: set_ramp_step = val[SPEED_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic load_settings(logic [BAND_W-1:0] t, logic [BAND_W-1:0] b,
                                 logic [BAND_W-1:0] d, logic [SPEED_W-1:0] m,
                                 logic [SPEED_W-1:0] s);
        write_reg(wtfp_pkg::REG_TARGET, t);
        write_reg(wtfp_pkg::REG_SLOW_BAND, b);
        write_reg(wtfp_pkg::REG_DRIP, d);
        write_reg(wtfp_pkg::REG_MAX_SPEED, CFG_DATA_W'(m));
        write_reg(wtfp_pkg::REG_RAMP_STEP, CFG_DATA_W'(s));
    endtask

    // wait until every beat is in and every result checked, then let the block settle
    task automatic drain();
        while (beats_taken != beats_queued || expected_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // settings with a bias toward the extremes
    task automatic shuffle_settings();
        logic [BAND_W-1:0]  t, b, d;
        logic [SPEED_W-1:0] m, s;
        case ($urandom_range(0, 3))
            0: t = '0;
            1: t = '1;
            default: t = BAND_W'($urandom());
        endcase
        case ($urandom_range(0, 4))
            0: b = '0;
            1: b = BAND_W'(1);
            2: b = '1;
            3: b = BAND_W'($urandom_range(1, 2000));
            default: b = BAND_W'($urandom());
        endcase
        case ($urandom_range(0, 3))
            0: d = '0;
            1: d = '1;
            2: d = BAND_W'($urandom_range(0, 500));
            default: d = BAND_W'($urandom());
        endcase
        case ($urandom_range(0, 4))
            0: m = '0;
            1: m = SPEED_W'(102);
            2: m = '1;
            default: m = SPEED_W'($urandom());
        endcase
        case ($urandom_range(0, 4))
            0: s = '0;
            1: s = SPEED_W'(1);
            2: s = SPEED_W'(100);
            3: s = '1;
            default: s = SPEED_W'($urandom());
        endcase
        load_settings(t, b, d, m, s);
    endtask

    // start, then a rising weight through the slowdown band up to the stop point
    task automatic add_fill_run();
        logic [TIME_W-1:0] t;
        longint            stop_at, span, remaining;
        int                k, stride;
        if ($urandom_range(0, 7) == 0)
            t = 32'hFFFF_FFF0 + $urandom_range(0, 15);
        else
            t = $urandom();
        add_beat(wtfp_pkg::CMD_START, WB'($urandom()), t);
        stop_at   = longint'(set_target) - longint'(set_drip);
        span      = longint'(set_band) + longint'(set_drip);
        remaining = span + longint'($urandom_range(0, 200));
        stride    = int'(span / 6) + 3;
        for (k = 0; k < 40 && remaining > 0; k++) begin
            t += $urandom_range(0, 8);
            if ($urandom_range(0, 19) == 0) add_noise();
            add_beat(wtfp_pkg::CMD_UPDATE, clamp_weight(stop_at - remaining), t);
            remaining -= longint'($urandom_range(0, stride));
        end
        t += $urandom_range(0, 8);
        add_beat(wtfp_pkg::CMD_UPDATE,
                 clamp_weight(stop_at + longint'($urandom_range(0, 3))), t);
    endtask

    task automatic random_phase(int quota, bit last);
        int first;
        shuffle_settings();
        steady = last;
        case ($urandom_range(0, 2))
            0: gap_pct = 0;
            1: gap_pct = 10;
            default: gap_pct = 35;
        endcase
        first = beats_queued;
        while (beats_queued - first < quota) begin
            if ($urandom_range(0, 4) != 0)
                add_fill_run();
            else
                repeat ($urandom_range(1, 3)) add_noise();
        end
        drain();
    endtask

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        in_if.valid   = 1'b0;
        in_if.command = wtfp_pkg::CMD_UPDATE;
        in_if.weight  = '0;
        in_if.now_ms  = '0;
        out_if.ready  = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = wtfp_pkg::REG_TARGET;
        cfg_if.data   = '0;
        i_rst_n       = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: taper, wrap of the time stamp, restart, stop, idle beats
        gap_pct = 20;
        load_settings(BAND_W'(1000), BAND_W'(100), BAND_W'(10), SPEED_W'(102), SPEED_W'(25));
        add_beat(wtfp_pkg::CMD_UPDATE, clamp_weight(0), 32'd0);
        add_beat(CMD_UNUSED, clamp_weight(W_MIN), 32'hFFFF_FFFF);
        add_beat(wtfp_pkg::CMD_STOP, clamp_weight(W_MAX), 32'd7);
        add_beat(wtfp_pkg::CMD_START, clamp_weight(0), 32'hFFFF_FFF0);
        add_beat(wtfp_pkg::CMD_UPDATE, clamp_weight(W_MIN), 32'hFFFF_FFF5);
        add_beat(wtfp_pkg::CMD_UPDATE, clamp_weight(500), 32'hFFFF_FFFF);
        add_beat(wtfp_pkg::CMD_UPDATE, clamp_weight(900), 32'd5);
        add_beat(wtfp_pkg::CMD_UPDATE, clamp_weight(950), 32'd10);
        add_beat(wtfp_pkg::CMD_START, clamp_weight(0), 32'd20);
        add_beat(wtfp_pkg::CMD_UPDATE, clamp_weight(980), 32'd30);
        add_beat(wtfp_pkg::CMD_UPDATE, clamp_weight(989), 32'd45);
        add_beat(wtfp_pkg::CMD_UPDATE, clamp_weight(990), 32'd50);
        add_beat(wtfp_pkg::CMD_UPDATE, clamp_weight(-1), 32'd60);
        add_beat(wtfp_pkg::CMD_START, clamp_weight(-1), 32'd100);
        add_beat(wtfp_pkg::CMD_UPDATE, clamp_weight(W_MAX), 32'd200);
        add_beat(wtfp_pkg::CMD_START, clamp_weight(0), 32'd300);
        add_beat(wtfp_pkg::CMD_UPDATE, clamp_weight(0), 32'd321);
        add_beat(wtfp_pkg::CMD_UPDATE, clamp_weight(0), 32'd340);
        add_beat(wtfp_pkg::CMD_STOP, clamp_weight(0), 32'd341);
        add_beat(wtfp_pkg::CMD_UPDATE, clamp_weight(0), 32'd342);
        drain();

        // directed: zero band, code saturation, oversized ramp step
        load_settings('1, '0, '1, '1, '1);
        add_beat(wtfp_pkg::CMD_START, clamp_weight(0), 32'd0);
        add_beat(wtfp_pkg::CMD_UPDATE, clamp_weight(-1), 32'd21);
        add_beat(wtfp_pkg::CMD_UPDATE, clamp_weight(W_MIN), 32'd22);
        add_beat(wtfp_pkg::CMD_UPDATE, clamp_weight(W_MAX), 32'd23);
        drain();

        repeat (7) random_phase(225, 1'b0);
        random_phase(225, 1'b1);

        if (expected_q.size() != 0) begin
            $error("%0d expected results never arrived", expected_q.size());
            errors++;
        end
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
src/wtfp_pkg.sv
src/wtfp_if.sv
src/weight_target_fill_pump_control.sv
src/wtfp_checker.sv
tb/weight_target_fill_pump_control_test.sv
